[rtl/nmr_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the memory range map.
// Used by nmr_range_cell and numa_memory_range_map_unit; depends on nothing.
package nmr_pkg;

    // Table sizes.
    localparam int RANGES = 32;
    localparam int NODES  = 8;

    // Derived widths.
    localparam int NODE_W     = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int HELD_W     = $clog2(RANGES + 1);
    localparam int PAGE_SHIFT = 12;
    localparam int PFN_W      = 64 - PAGE_SHIFT;

    // Request type codes.
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Lookup token handed from cell to cell along the range chain.
    typedef struct packed {
        logic              active;
        logic              hit;
        logic [NODE_W-1:0] node;
    } tok_t;

endpackage

[rtl/nmr_range_cell.sv]
`timescale 1ns / 1ps
// One range cell of the chain: holds one page range and its owner node.
// Depends on nmr_pkg for widths and the token type.
module nmr_range_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [nmr_pkg::PFN_W-1:0]   load_first,
    input  logic [nmr_pkg::PFN_W-1:0]   load_limit,
    input  logic [nmr_pkg::NODE_W-1:0]  load_owner,
    input  logic                        in_use,
    input  logic [nmr_pkg::PFN_W-1:0]   page_frame,
    input  nmr_pkg::tok_t               tok_in,
    output nmr_pkg::tok_t               tok_out
);

    logic [nmr_pkg::PFN_W-1:0]  first_reg;
    logic [nmr_pkg::PFN_W-1:0]  limit_reg;
    logic [nmr_pkg::NODE_W-1:0] owner_reg;
    nmr_pkg::tok_t              tok_reg;
    nmr_pkg::tok_t              tok_next;
    logic                       in_range;

    // Range contents are written once when the cell is filled.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            first_reg <= load_first;
            limit_reg <= load_limit;
            owner_reg <= load_owner;
        end
    end

    // The first held range that contains the page claims the token.
    assign in_range = in_use && (page_frame >= first_reg) && (page_frame < limit_reg);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && !tok_in.hit && in_range)
        begin
            tok_next.hit  = 1'b1;
            tok_next.node = owner_reg;
        end
    end

    // Hand the token to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[rtl/numa_memory_range_map_unit.sv]
`timescale 1ns / 1ps
// Top level of the NUMA memory range map: node table, range cell chain, control.
// Depends on nmr_pkg and nmr_range_cell.

// The block takes one request at a time. An add request works through S_ADD1
// (start page) and S_ADD2 (span), loading its result into the output register
// in S_ADD2 once that register is free. A lookup sends a token down the chain
// of RANGES range cells, one cell per cycle; the token leaving the last cell
// is captured in S_LOOK, its result loaded likewise in S_LDONE. The next
// request is taken once the previous result has been loaded into the output
// register, even while that result still waits for out_ready. Lookups miss on a
// table with no held ranges; an empty node reads as start all ones, span zero.
module numa_memory_range_map_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic [31:0]                domain,
    input  logic                       enabled,
    input  logic [63:0]                base_address,
    input  logic [63:0]                range_length,
    input  logic [51:0]                page_frame,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 result_node,
    output logic                       matched,
    output logic                       range_stored,
    output logic [63:0]                node_first_page,
    output logic [63:0]                node_span,
    output logic [3:0]                 node_count
);

    localparam int NW = nmr_pkg::NODE_W;
    localparam int HW = nmr_pkg::HELD_W;
    localparam int PW = nmr_pkg::PFN_W;
    localparam int PS = nmr_pkg::PAGE_SHIFT;

    // Control states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD1  = 3'd1;
    localparam logic [2:0] S_ADD2  = 3'd2;
    localparam logic [2:0] S_LOOK  = 3'd3;
    localparam logic [2:0] S_LDONE = 3'd4;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;

    // Captured request.
    logic          en_ok_reg;
    logic [NW-1:0] dom_reg;
    logic [63:0]   base_reg;
    logic [63:0]   len_reg;
    logic [PW-1:0] pfn_reg;
    logic          launch_reg;

    // Add pipeline registers.
    logic [PW-1:0] epfn_reg;
    logic [63:0]   tend_reg;
    logic [63:0]   new_start_reg;
    logic [63:0]   old_pages_reg;

    // Lookup result captured at the end of the chain.
    logic          found_hit_reg;
    logic [NW-1:0] found_node_reg;

    // Node table and counters.
    logic [nmr_pkg::NODES-1:0] present_reg;
    logic [63:0]   start_reg [nmr_pkg::NODES];
    logic [63:0]   pages_reg [nmr_pkg::NODES];
    logic [HW-1:0] held_reg;
    logic [NW-1:0] top_reg;

    // Output register.
    logic          out_valid_reg;
    logic [2:0]    res_node_reg;
    logic          matched_reg;
    logic          stored_reg;
    logic [63:0]   first_page_reg;
    logic [63:0]   span_reg;
    logic [3:0]    count_reg;

    logic          in_fire;
    logic          out_free;
    logic          add_done;
    logic          look_done;
    logic          table_room;
    logic          add_commit;
    logic [NW-1:0] rd_idx;
    logic [63:0]   rd_start;
    logic [63:0]   rd_pages;
    logic [63:0]   cur_start;
    logic [63:0]   cur_pages;
    logic [PW-1:0] spfn;
    logic [63:0]   end_sum;
    logic [63:0]   end_page;
    logic [63:0]   pages_new;
    logic [NW-1:0] top_next;

    nmr_pkg::tok_t tok_w [nmr_pkg::RANGES+1];

    // Handshake.
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign add_done  = (state_reg == S_ADD2) && out_free;
    assign look_done = (state_reg == S_LDONE) && out_free;

    // Control sequence.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (req_type == nmr_pkg::REQ_LOOKUP) ? S_LOOK : S_ADD1;
                end
            end
            S_ADD1:
            begin
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOOK:
            begin
                if (tok_w[nmr_pkg::RANGES].active)
                begin
                    state_next = S_LDONE;
                end
            end
            S_LDONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= in_fire && (req_type == nmr_pkg::REQ_LOOKUP);
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            en_ok_reg <= enabled && (domain < 32'(nmr_pkg::NODES));
            dom_reg   <= domain[NW-1:0];
            base_reg  <= base_address;
            len_reg   <= range_length;
            pfn_reg   <= page_frame;
        end
    end

    // Node table read port, shared by the add and lookup paths.
    assign rd_idx   = (state_reg == S_LDONE) ? found_node_reg : dom_reg;
    assign rd_start = start_reg[rd_idx];
    assign rd_pages = pages_reg[rd_idx];

    // Add, first step: page numbers and the lowered start page.
    assign spfn      = base_reg[63:PS];
    assign cur_start = present_reg[dom_reg] ? rd_start : '1;
    assign cur_pages = present_reg[dom_reg] ? rd_pages : '0;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD1)
        begin
            epfn_reg      <= PW'((base_reg + len_reg) >> PS);
            tend_reg      <= 64'(spfn) + 64'(len_reg[63:PS]);
            new_start_reg <= (64'(spfn) < cur_start) ? 64'(spfn) : cur_start;
            old_pages_reg <= cur_pages;
        end
    end

    // Add, second step: widen the span and pick the new top domain.
    assign end_sum    = new_start_reg + old_pages_reg;
    assign end_page   = tend_reg - new_start_reg;
    assign pages_new  = (tend_reg > end_sum) ? end_page : old_pages_reg;
    assign table_room = (held_reg < HW'(nmr_pkg::RANGES));
    assign add_commit = add_done && en_ok_reg;
    assign top_next   = (add_commit && (dom_reg > top_reg)) ? dom_reg : top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            held_reg    <= '0;
            top_reg     <= '0;
            for (int n = 0; n < nmr_pkg::NODES; n++)
            begin
                start_reg[n] <= '1;
                pages_reg[n] <= '0;
            end
        end
        else
        begin
            top_reg <= top_next;
            if (add_commit)
            begin
                present_reg[dom_reg] <= 1'b1;
                start_reg[dom_reg]   <= new_start_reg;
                pages_reg[dom_reg]   <= pages_new;
                if (table_room)
                begin
                    held_reg <= held_reg + HW'(1);
                end
            end
        end
    end

    // Range cell chain; the lookup token enters at the first cell.
    assign tok_w[0] = '{active: launch_reg, hit: 1'b0, node: '0};

    for (genvar i = 0; i < nmr_pkg::RANGES; i++)
    begin : g_cell
        nmr_range_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (add_commit && table_room && (held_reg == HW'(i))),
            .load_first (spfn),
            .load_limit (epfn_reg),
            .load_owner (dom_reg),
            .in_use     (held_reg > HW'(i)),
            .page_frame (pfn_reg),
            .tok_in     (tok_w[i]),
            .tok_out    (tok_w[i+1])
        );
    end

    // Capture the token leaving the last cell.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_LOOK) && tok_w[nmr_pkg::RANGES].active)
        begin
            found_hit_reg  <= tok_w[nmr_pkg::RANGES].hit;
            found_node_reg <= tok_w[nmr_pkg::RANGES].node;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (add_done || look_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (add_done)
        begin
            res_node_reg   <= en_ok_reg ? 3'(dom_reg) : 3'd0;
            matched_reg    <= 1'b0;
            stored_reg     <= en_ok_reg && table_room;
            first_page_reg <= en_ok_reg ? new_start_reg : 64'd0;
            span_reg       <= en_ok_reg ? pages_new : 64'd0;
            count_reg      <= 4'(top_next) + 4'd1;
        end
        else if (look_done)
        begin
            res_node_reg   <= found_hit_reg ? 3'(found_node_reg) : 3'd0;
            matched_reg    <= found_hit_reg;
            stored_reg     <= 1'b0;
            first_page_reg <= found_hit_reg ? rd_start : 64'd0;
            span_reg       <= found_hit_reg ? rd_pages : 64'd0;
            count_reg      <= 4'(top_reg) + 4'd1;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_node     = res_node_reg;
    assign matched         = matched_reg;
    assign range_stored    = stored_reg;
    assign node_first_page = first_page_reg;
    assign node_span       = span_reg;
    assign node_count      = count_reg;

    // The fill count never passes the table size.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HW'(nmr_pkg::RANGES))
        else $error("range fill count exceeds table size");

    // A token only leaves the chain while a lookup is in flight.
    a_tok_state: assert property (@(posedge clk) disable iff (!rst_n)
        tok_w[nmr_pkg::RANGES].active |-> (state_reg == S_LOOK))
        else $error("lookup token left chain outside lookup");

    // A result is never both a hit and a stored range.
    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(matched_reg && stored_reg))
        else $error("result flags both hit and store");

    // The fill count only moves at the end of an add.
    a_held_step: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != $past(held_reg)) |-> ($past(state_reg) == S_ADD2))
        else $error("fill count changed outside an add");

    // The top domain never falls.
    a_top_mono: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg >= $past(top_reg))
        else $error("top domain decreased");

endmodule
